FILE: design/cbavg_pkg.sv
// ----------------------------------------------------------------------------
// cbavg_pkg
// Shared widths, default block sizes and inter-stage word types of the
// cascaded block averager.
// ----------------------------------------------------------------------------
`default_nettype none

package cbavg_pkg;

  // Default block sizes
  localparam int CURRENT_BLOCK_DEF = 50;
  localparam int GROUP_SIZE_DEF    = 3;
  localparam int VOLTAGE_BLOCK_DEF = 100;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int CAVG_W   = 15;

  // Widest block sum (100 samples of 16 bits) and widest group sum
  // (three half-scaled blocks of 15 bits)
  localparam int BSUM_W = 23;
  localparam int GSUM_W = 17;

  // Word from the block accumulators to the block dividers
  typedef struct packed {
    logic              vdone;
    logic [BSUM_W-1:0] vsum;
    logic              cdone;
    logic [BSUM_W-1:0] csum;
  } acc_tok_t;

  // Word from the block dividers to the output stage
  typedef struct packed {
    logic                vdone;
    logic [SAMPLE_W-1:0] vavg;
    logic                gdone;
    logic [GSUM_W-1:0]   gsum;
  } grp_tok_t;

endpackage

`default_nettype wire

FILE: design/cbavg_divc.sv
// ----------------------------------------------------------------------------
// cbavg_divc
// Unsigned division by a constant: multiply by a rounded-up reciprocal and
// shift. The shift is chosen so the quotient is exact for every input value.
// ----------------------------------------------------------------------------
`default_nettype none

module cbavg_divc #(
  parameter int IN_W    = 23,
  parameter int OUT_W   = 16,
  parameter int DIVISOR = 100
) (
  input  logic [IN_W-1:0]  num_i,
  output logic [OUT_W-1:0] quo_o
);

  localparam int SHIFT  = IN_W + $clog2(DIVISOR);
  localparam int MULT_W = IN_W + 2;
  localparam int PROD_W = IN_W + MULT_W;
  localparam logic [63:0] MULT =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PROD_W-1:0] prod;

  // Multiply by the reciprocal, keep the integer part
  assign prod  = PROD_W'(num_i) * PROD_W'(MULT[MULT_W-1:0]);
  assign quo_o = OUT_W'(prod >> SHIFT);

endmodule

`default_nettype wire

FILE: design/cbavg_acc.sv
// ----------------------------------------------------------------------------
// cbavg_acc
// Block accumulators: add each sample into its running block sum and pass
// the finished sum on when a block closes.
// ----------------------------------------------------------------------------
`default_nettype none

module cbavg_acc
  import cbavg_pkg::*;
#(
  parameter int CURRENT_BLOCK = CURRENT_BLOCK_DEF,
  parameter int VOLTAGE_BLOCK = VOLTAGE_BLOCK_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  logic [SAMPLE_W-1:0] voltage_sample_i,
  input  logic [SAMPLE_W-1:0] current_sample_i,
  output logic                vld_o,
  output acc_tok_t            tok_o
);

  localparam int CSUM_W = $clog2(CURRENT_BLOCK * 65535 + 1);
  localparam int CCNT_W = $clog2(CURRENT_BLOCK + 1);
  localparam int VSUM_W = $clog2(VOLTAGE_BLOCK * 65535 + 1);
  localparam int VCNT_W = $clog2(VOLTAGE_BLOCK + 1);

  logic [CSUM_W-1:0] csum_q, csum_d;
  logic [CCNT_W-1:0] ccnt_q;
  logic [VSUM_W-1:0] vsum_q, vsum_d;
  logic [VCNT_W-1:0] vcnt_q;
  logic              cdone, vdone, step;
  logic              vld_q;
  acc_tok_t          tok_q;

  assign step   = adv_i & vld_i;
  assign csum_d = csum_q + CSUM_W'(current_sample_i);
  assign vsum_d = vsum_q + VSUM_W'(voltage_sample_i);
  assign cdone  = (ccnt_q == CCNT_W'(CURRENT_BLOCK - 1));
  assign vdone  = (vcnt_q == VCNT_W'(VOLTAGE_BLOCK - 1));

  // Advance the running sums, restart them when a block closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0;
      ccnt_q <= '0;
      vsum_q <= '0;
      vcnt_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (adv_i) begin
        vld_q <= vld_i;
      end
      if (step) begin
        if (cdone) begin
          csum_q <= '0;
          ccnt_q <= '0;
        end else begin
          csum_q <= csum_d;
          ccnt_q <= ccnt_q + CCNT_W'(1);
        end
        if (vdone) begin
          vsum_q <= '0;
          vcnt_q <= '0;
        end else begin
          vsum_q <= vsum_d;
          vcnt_q <= vcnt_q + VCNT_W'(1);
        end
      end
    end
  end

  // Hold the finished sums for the divider stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q.cdone <= cdone;
      tok_q.csum  <= BSUM_W'(csum_d);
      tok_q.vdone <= vdone;
      tok_q.vsum  <= BSUM_W'(vsum_d);
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: design/cbavg_grp.sv
// ----------------------------------------------------------------------------
// cbavg_grp
// Block dividers and group accumulator: scale each finished block, add the
// half-scaled current blocks into the group sum and pass it on when the
// group is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module cbavg_grp
  import cbavg_pkg::*;
#(
  parameter int CURRENT_BLOCK = CURRENT_BLOCK_DEF,
  parameter int GROUP_SIZE    = GROUP_SIZE_DEF,
  parameter int VOLTAGE_BLOCK = VOLTAGE_BLOCK_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     vld_i,
  input  acc_tok_t tok_i,
  output logic     vld_o,
  output grp_tok_t tok_o
);

  localparam int GSUM_L = $clog2(GROUP_SIZE * 32767 + 1);
  localparam int GCNT_W = $clog2(GROUP_SIZE + 1);

  logic [SAMPLE_W-1:0] vavg;
  logic [CAVG_W-1:0]   half_mean;
  logic [GSUM_L-1:0]   gsum_q, gsum_d;
  logic [GCNT_W-1:0]   gcnt_q;
  logic                gdone, step;
  logic                vld_q;
  grp_tok_t            tok_q;

  cbavg_divc #(
    .IN_W    (BSUM_W),
    .OUT_W   (SAMPLE_W),
    .DIVISOR (VOLTAGE_BLOCK)
  ) u_vdiv (
    .num_i (tok_i.vsum),
    .quo_o (vavg)
  );

  cbavg_divc #(
    .IN_W    (BSUM_W),
    .OUT_W   (CAVG_W),
    .DIVISOR (2 * CURRENT_BLOCK)
  ) u_cdiv (
    .num_i (tok_i.csum),
    .quo_o (half_mean)
  );

  assign step   = adv_i & vld_i & tok_i.cdone;
  assign gsum_d = gsum_q + GSUM_L'(half_mean);
  assign gdone  = tok_i.cdone & (gcnt_q == GCNT_W'(GROUP_SIZE - 1));

  // Collect half-scaled blocks, restart when the group is complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsum_q <= '0;
      gcnt_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (adv_i) begin
        vld_q <= vld_i;
      end
      if (step) begin
        if (gdone) begin
          gsum_q <= '0;
          gcnt_q <= '0;
        end else begin
          gsum_q <= gsum_d;
          gcnt_q <= gcnt_q + GCNT_W'(1);
        end
      end
    end
  end

  // Hold the block average and group sum for the output stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q.vdone <= tok_i.vdone;
      tok_q.vavg  <= vavg;
      tok_q.gdone <= gdone;
      tok_q.gsum  <= GSUM_W'(gsum_d);
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: design/cbavg_hold.sv
// ----------------------------------------------------------------------------
// cbavg_hold
// Output stage: divide the group sum, update the held averages and keep the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cbavg_hold
  import cbavg_pkg::*;
#(
  parameter int GROUP_SIZE = GROUP_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  grp_tok_t            tok_i,
  output logic                vld_o,
  output logic [SAMPLE_W-1:0] voltage_average_o,
  output logic                voltage_updated_o,
  output logic [CAVG_W-1:0]   current_average_o,
  output logic                current_updated_o
);

  logic [CAVG_W-1:0]   cavg;
  logic [SAMPLE_W-1:0] held_v_q;
  logic [CAVG_W-1:0]   held_c_q;
  logic                vupd_q, cupd_q, vld_q;

  cbavg_divc #(
    .IN_W    (GSUM_W),
    .OUT_W   (CAVG_W),
    .DIVISOR (GROUP_SIZE)
  ) u_gdiv (
    .num_i (tok_i.gsum),
    .quo_o (cavg)
  );

  // Update held values per voltage block and current group, else drop flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      held_v_q <= '0;
      held_c_q <= '0;
      vupd_q   <= 1'b0;
      cupd_q   <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      if (vld_i) begin
        vupd_q <= tok_i.vdone;
        cupd_q <= tok_i.gdone;
        if (tok_i.vdone) begin
          held_v_q <= tok_i.vavg;
        end
        if (tok_i.gdone) begin
          held_c_q <= cavg;
        end
      end
    end
  end

  assign vld_o             = vld_q;
  assign voltage_average_o = held_v_q;
  assign voltage_updated_o = vupd_q;
  assign current_average_o = held_c_q;
  assign current_updated_o = cupd_q;

endmodule

`default_nettype wire

FILE: design/cascaded_block_average_vi.sv
// ----------------------------------------------------------------------------
// cascaded_block_average_vi
// Cascaded boxcar averager for one voltage and one current ADC channel.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one ADC scan per word: the voltage and current
//   codes. The master stream returns one word per scan with the held voltage
//   block average, the held current average (mean of GROUP_SIZE blocks, each
//   half its block mean) and two flags in tuser that mark the scans which
//   closed a voltage block or a current group.
//   Pipeline: three register stages (block accumulators, block dividers with
//   the group accumulator, group divider with the held values); a scan
//   passes through them in that order before its result is valid.
//   Throughput: one scan per cycle while no result is stalled; the running
//   sums and constant-reciprocal dividers take a word whenever adv is high.
//   Stall: all stages advance together; while a result waits on the master
//   side, s_axis_tready_o is low and every stage holds its word.
//   Reset: sums, counts and held averages clear to zero, no word is valid.
//   Before the first completed block the averages read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_block_average_vi
  import cbavg_pkg::*;
#(
  parameter int CURRENT_BLOCK = CURRENT_BLOCK_DEF,
  parameter int GROUP_SIZE    = GROUP_SIZE_DEF,
  parameter int VOLTAGE_BLOCK = VOLTAGE_BLOCK_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] voltage_sample, [31:16] current_sample
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] voltage_average, [30:16] current_average, [31] zero
  output logic [31:0] m_axis_tdata_o,
  // [0] voltage_updated, [1] current_updated
  output logic [1:0]  m_axis_tuser_o
);

  logic                adv;
  logic                acc_vld, grp_vld, out_vld;
  acc_tok_t            acc_tok;
  grp_tok_t            grp_tok;
  logic [SAMPLE_W-1:0] vavg;
  logic [CAVG_W-1:0]   cavg;
  logic                vupd, cupd;

  // Advance the whole pipe unless a result is stalled
  assign adv             = ~out_vld | m_axis_tready_i;
  assign s_axis_tready_o = adv;

  cbavg_acc #(
    .CURRENT_BLOCK (CURRENT_BLOCK),
    .VOLTAGE_BLOCK (VOLTAGE_BLOCK)
  ) u_acc (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .vld_i            (s_axis_tvalid_i),
    .voltage_sample_i (s_axis_tdata_i[15:0]),
    .current_sample_i (s_axis_tdata_i[31:16]),
    .vld_o            (acc_vld),
    .tok_o            (acc_tok)
  );

  cbavg_grp #(
    .CURRENT_BLOCK (CURRENT_BLOCK),
    .GROUP_SIZE    (GROUP_SIZE),
    .VOLTAGE_BLOCK (VOLTAGE_BLOCK)
  ) u_grp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (acc_vld),
    .tok_i  (acc_tok),
    .vld_o  (grp_vld),
    .tok_o  (grp_tok)
  );

  cbavg_hold #(
    .GROUP_SIZE (GROUP_SIZE)
  ) u_hold (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .vld_i             (grp_vld),
    .tok_i             (grp_tok),
    .vld_o             (out_vld),
    .voltage_average_o (vavg),
    .voltage_updated_o (vupd),
    .current_average_o (cavg),
    .current_updated_o (cupd)
  );

  // Pack the result word
  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {1'b0, cavg, vavg};
  assign m_axis_tuser_o  = {cupd, vupd};

endmodule

`default_nettype wire

FILE: design/cbavg_chk.sv
// ----------------------------------------------------------------------------
// cbavg_chk
// Port-level checks of the cascaded block averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbavg_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // Hold a stalled result word
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result word changed while stalled");

  // Take a scan exactly when no result is stalled
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // Keep the voltage average unless a voltage block closed
  a_vhold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) ##1 (m_axis_tvalid_o && !m_axis_tuser_o[0])
      |-> (m_axis_tdata_o[15:0] == $past(m_axis_tdata_o[15:0])))
    else $error("voltage average changed without update flag");

  // Keep the current average unless a current group closed
  a_chold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) ##1 (m_axis_tvalid_o && !m_axis_tuser_o[1])
      |-> (m_axis_tdata_o[30:16] == $past(m_axis_tdata_o[30:16])))
    else $error("current average changed without update flag");

endmodule

bind cascaded_block_average_vi cbavg_chk u_chk (.*);

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cascaded voltage/current block averager. A
// scoreboard class predicts the held averages and the update flags for every
// accepted scan and checks each result word in order. Stimulus starts with a
// short directed part, then runs per-channel segments of full-scale, zero,
// near-extreme, low and uniform codes aligned to the block boundaries. The
// sender works in bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import cbavg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SCANS   = 1950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 100;
  // Current blocks and current groups both line up every 150 scans
  localparam int SEG_ALIGN   = 150;

  typedef enum int {
    CH_MAX,
    CH_ZERO,
    CH_EXTREME,
    CH_LOW,
    CH_UNIFORM
  } chan_mode_e;

  typedef enum int {
    RX_FULL,
    RX_COIN,
    RX_SPARSE,
    RX_LONG_STALL
  } rx_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] current;
    logic [SAMPLE_W-1:0] voltage;
  } scan_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] vavg;
    logic                vupd;
    logic [CAVG_W-1:0]   cavg;
    logic                cupd;
  } avg_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: running-sum predictor plus the queue of expected words
  // --------------------------------------------------------------------------
  class avg_scoreboard;
    logic [21:0]         cur_sum;
    logic [5:0]          cur_cnt;
    logic [GSUM_W-1:0]   grp_sum;
    logic [1:0]          grp_cnt;
    logic [BSUM_W-1:0]   volt_sum;
    logic [6:0]          volt_cnt;
    logic [CAVG_W-1:0]   held_cur;
    logic [SAMPLE_W-1:0] held_volt;
    avg_word_t           expected_q[$];
    int                  errors;
    int                  checked;
    int                  volt_updates;
    int                  cur_updates;

    function new();
      cur_sum      = '0;
      cur_cnt      = '0;
      grp_sum      = '0;
      grp_cnt      = '0;
      volt_sum     = '0;
      volt_cnt     = '0;
      held_cur     = '0;
      held_volt    = '0;
      errors       = 0;
      checked      = 0;
      volt_updates = 0;
      cur_updates  = 0;
    endfunction

    // Advance both block paths by one scan and queue the word it causes
    function void note_scan(scan_t s);
      logic [31:0] half_mean;
      logic [31:0] quot;
      avg_word_t   w;
      w.vupd = 1'b0;
      w.cupd = 1'b0;

      cur_sum = cur_sum + 22'(s.current);
      cur_cnt = cur_cnt + 6'd1;
      if (cur_cnt >= CURRENT_BLOCK_DEF) begin
        half_mean = 32'(cur_sum) / (2 * CURRENT_BLOCK_DEF);
        cur_sum   = '0;
        cur_cnt   = '0;
        grp_sum   = grp_sum + half_mean[GSUM_W-1:0];
        grp_cnt   = grp_cnt + 2'd1;
        if (grp_cnt >= GROUP_SIZE_DEF) begin
          quot     = 32'(grp_sum) / GROUP_SIZE_DEF;
          held_cur = quot[CAVG_W-1:0];
          grp_sum  = '0;
          grp_cnt  = '0;
          w.cupd   = 1'b1;
          cur_updates++;
        end
      end

      volt_sum = volt_sum + BSUM_W'(s.voltage);
      volt_cnt = volt_cnt + 7'd1;
      if (volt_cnt >= VOLTAGE_BLOCK_DEF) begin
        quot      = 32'(volt_sum) / VOLTAGE_BLOCK_DEF;
        held_volt = quot[SAMPLE_W-1:0];
        volt_sum  = '0;
        volt_cnt  = '0;
        w.vupd    = 1'b1;
        volt_updates++;
      end

      w.vavg = held_volt;
      w.cavg = held_cur;
      expected_q.push_back(w);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("[%0t] mismatch on word %0d: %s got 0x%0h want 0x%0h",
                 $realtime, checked, what, got, want);
    endtask

    // Compare one result word against the oldest expectation
    task check_result(logic [31:0] tdata, logic [1:0] tuser);
      avg_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, tdata", tdata, '0);
        return;
      end
      w = expected_q.pop_front();
      if (tdata[15:0] !== w.vavg)
        report_mismatch("voltage_average", 32'(tdata[15:0]), 32'(w.vavg));
      if (tdata[30:16] !== w.cavg)
        report_mismatch("current_average", 32'(tdata[30:16]), 32'(w.cavg));
      if (tdata[31] !== 1'b0)
        report_mismatch("tdata pad bit", 32'(tdata[31]), 32'd0);
      if (tuser[0] !== w.vupd)
        report_mismatch("voltage_updated", 32'(tuser[0]), 32'(w.vupd));
      if (tuser[1] !== w.cupd)
        report_mismatch("current_updated", 32'(tuser[1]), 32'(w.cupd));
      checked++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cascaded_block_average_vi DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  avg_scoreboard sb = new();
  scan_t         scan_q[$];
  int            cycle_cnt = 0;

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_code(chan_mode_e m);
    logic [15:0] code;
    case (m)
      CH_MAX:  code = 16'hFFFF;
      CH_ZERO: code = 16'h0000;
      CH_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       code = 16'h0000;
          1:       code = 16'hFFFF;
          2:       code = 16'h0001;
          3:       code = 16'hFFFE;
          4:       code = 16'h8000;
          default: code = 16'h7FFF;
        endcase
      end
      CH_LOW:  code = 16'($urandom_range(0, 255));
      default: code = 16'($urandom_range(0, 65535));
    endcase
    return code;
  endfunction

  function automatic chan_mode_e pick_mode();
    chan_mode_e m;
    case ($urandom_range(0, 7))
      0, 1:    m = CH_MAX;
      2:       m = CH_ZERO;
      3:       m = CH_EXTREME;
      4:       m = CH_LOW;
      default: m = CH_UNIFORM;
    endcase
    return m;
  endfunction

  task automatic build_scans();
    scan_t      s;
    chan_mode_e vmode;
    chan_mode_e cmode;
    int         seg_end;
    // Directed: field extremes and alternating bit patterns
    s = '{current: 16'h0000, voltage: 16'h0000}; scan_q.push_back(s);
    s = '{current: 16'hFFFF, voltage: 16'hFFFF}; scan_q.push_back(s);
    s = '{current: 16'h0000, voltage: 16'hFFFF}; scan_q.push_back(s);
    s = '{current: 16'hFFFF, voltage: 16'h0000}; scan_q.push_back(s);
    s = '{current: 16'hAAAA, voltage: 16'h5555}; scan_q.push_back(s);
    s = '{current: 16'h5555, voltage: 16'hAAAA}; scan_q.push_back(s);
    s = '{current: 16'h8000, voltage: 16'h7FFF}; scan_q.push_back(s);
    s = '{current: 16'h7FFF, voltage: 16'h8000}; scan_q.push_back(s);
    s = '{current: 16'h0001, voltage: 16'hFFFE}; scan_q.push_back(s);
    s = '{current: 16'hFFFE, voltage: 16'h0001}; scan_q.push_back(s);
    // Random: segments end on block-aligned boundaries so that full-scale
    // runs reach the top of both averages
    while (scan_q.size() < NUM_SCANS) begin
      vmode   = pick_mode();
      cmode   = pick_mode();
      seg_end = (scan_q.size() / SEG_ALIGN + 1) * SEG_ALIGN;
      while (scan_q.size() < seg_end) begin
        s.voltage = pick_code(vmode);
        s.current = pick_code(cmode);
        scan_q.push_back(s);
      end
    end
  endtask

  // Hold one scan on the slave side until it is taken
  task automatic send_scan(scan_t s);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {s.current, s.voltage};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_scan(s);
  endtask

  // Feed the whole queue in bursts with random gaps
  task automatic send_all();
    int burst_left;
    int gap;
    burst_left = 0;
    foreach (scan_q[i]) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(100, 300);
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(0, 6);
        end
        if (gap > 0) begin
          s_axis_tvalid_i <= 1'b0;
          s_axis_tdata_i  <= $urandom;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_scan(scan_q[i]);
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode       = RX_FULL;
  int       rx_mode_left  = 0;
  int       rx_stall_left = 0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(50, 400);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FULL:   m_axis_tready_i <= 1'b1;
      RX_COIN:   m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall_left > 0) begin
          m_axis_tready_i <= 1'b0;
          rx_stall_left   <= rx_stall_left - 1;
        end else begin
          m_axis_tready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left <= $urandom_range(5, 20);
        end
      end
    endcase
  end

  // Check every word taken on the master side
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    build_scans();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_all();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d result words for %0d scans in %0d cycles.",
             sb.checked, scan_q.size(), cycle_cnt);
    $display("Saw %0d voltage block updates and %0d current group updates, %0d mismatches.",
             sb.volt_updates, sb.cur_updates, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/cbavg_pkg.sv
design/cbavg_divc.sv
design/cbavg_acc.sv
design/cbavg_grp.sv
design/cbavg_hold.sv
design/cascaded_block_average_vi.sv
design/cbavg_chk.sv
verif/tb.sv
